// ===== src/base64_stream_decoder_defines.svh =====
// Assertion helpers for the decoder RTL, included by b64d_outbuf.
// Each expects clk and rst_n in the enclosing module.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64d_pkg.sv =====
package b64d_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  localparam logic [7:0] CHAR_PAD    = 8'h3D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
  localparam logic [7:0] CHAR_DIG_0  = 8'h30;
  localparam logic [7:0] CHAR_DIG_9  = 8'h39;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_USCORE = 8'h5F;

  localparam logic [7:0] LC_OFFSET  = 8'd26;
  localparam logic [7:0] DIG_OFFSET = 8'd52;
  localparam logic [5:0] SEXTET_62  = 6'd62;
  localparam logic [5:0] SEXTET_63  = 6'd63;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Results of one request, drained one per output handshake.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            data;
    logic            done;
    logic            err;
  } res_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      s.val = 6'(c - CHAR_UC_A);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      s.val = 6'(c - CHAR_LC_A + LC_OFFSET);
    end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
      s.val = 6'(c - CHAR_DIG_0 + DIG_OFFSET);
    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
      s.val = SEXTET_62;
    end else if (c == CHAR_SLASH || c == CHAR_USCORE) begin
      s.val = SEXTET_63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== src/base64_stream_decoder.sv =====
// A character accepted at the input waits in char_r until the output buffer
// is free. Throughput: one character per cycle while each yields at most one
// result and out_ready is high; a character that yields several results holds
// the input until the single-entry output port has drained the result buffer.
// Reset (rst_n low, synchronous): message state clears and output_limit
// returns to 65535.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_last_of_run,
  output logic        out_message_done,
  output logic        out_decode_error
);

  logic           hold_v_r;
  logic [7:0]     char_r;
  logic           eom_r;
  logic           free, fire;
  b64d_pkg::res_t res;

  assign fire     = hold_v_r && free;
  assign in_ready = !hold_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_ready) begin
      hold_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_code;
      eom_r  <= in_end_of_message;
    end
  end

  b64d_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (fire),
    .char_code   (char_r),
    .eom         (eom_r),
    .res         (res)
  );

  b64d_outbuf u_outbuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (fire),
    .res          (res),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (out_data_byte),
    .data_valid   (out_data_valid),
    .last_of_run  (out_last_of_run),
    .message_done (out_message_done),
    .decode_error (out_decode_error)
  );

endmodule

// ===== src/b64d_core.sv =====
module b64d_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               step,
  input  logic [7:0]         char_code,
  input  logic               eom,
  output b64d_pkg::res_t     res
);

  localparam int CW   = b64d_pkg::COUNT_WIDTH;
  localparam int CmpW = (CW >= 16) ? CW + 1 : 17;
  localparam logic [CmpW-1:0] CountMax = CmpW'({CW{1'b1}});

  logic [15:0]        limit_r;
  logic [2:0][5:0]    store_r, store_nxt;
  logic [1:0]         fill_r, fill_nxt;
  logic [1:0]         pad_r, pad_nxt;
  logic [CW-1:0]      emitted_r, emitted_nxt;
  logic               err_r, err_nxt;

  b64d_pkg::sextet_t  sx;
  logic               is_space, is_pad, take, grp, left_one, left_multi, over, emit;
  logic               err1, err2;
  logic [1:0]         pad1, fill1, nb;
  logic [2:0][5:0]    store1;
  logic [5:0]         v;
  logic [CmpW-1:0]    total;
  logic [2:0][7:0]    bytes;

  always_comb begin
    sx       = b64d_pkg::sextet_of(char_code);
    is_space = (char_code == b64d_pkg::CHAR_SPACE) || (char_code == b64d_pkg::CHAR_TAB) ||
               (char_code == b64d_pkg::CHAR_LF) || (char_code == b64d_pkg::CHAR_CR);
    is_pad   = (char_code == b64d_pkg::CHAR_PAD);

    err1   = err_r;
    pad1   = pad_r;
    fill1  = fill_r;
    store1 = store_r;
    take   = 1'b0;
    v      = '0;
    grp    = 1'b0;

    if (!err_r && !is_space) begin
      if (is_pad) begin
        if (pad_r[1]) begin
          err1 = 1'b1;
        end else begin
          pad1 = pad_r + 2'd1;
          take = 1'b1;
        end
      end else if (pad_r != 2'd0) begin
        err1 = 1'b1;
      end else if (!sx.ok) begin
        err1 = 1'b1;
      end else begin
        take = 1'b1;
        v    = sx.val;
      end
    end

    if (take) begin
      if (fill_r != 2'd3) begin
        store1[fill_r] = v;
        fill1          = fill_r + 2'd1;
      end else begin
        grp   = 1'b1;
        fill1 = 2'd0;
      end
    end

    // A completed group leaves nothing over, so one adder serves both cases.
    left_one   = eom && !err1 && !grp && (fill1 == 2'd1);
    left_multi = eom && !err1 && !grp && fill1[1];
    nb         = grp ? 2'(2'd3 - pad1) : 2'(fill1 - 2'd1);
    total      = CmpW'(emitted_r) + CmpW'(nb);
    over       = (total > CmpW'(limit_r)) || (total > CountMax);
    emit       = (grp || left_multi) && !over;
    err2       = err1 || ((grp || left_multi) && over) || left_one;

    bytes[0] = {store1[0], store1[1][5:4]};
    bytes[1] = {store1[1][3:0], store1[2][5:2]};
    bytes[2] = {store1[2][1:0], v};

    res.bytes = bytes;
    res.data  = 1'b1;
    res.done  = 1'b0;
    res.err   = 1'b0;
    res.cnt   = emit ? nb : 2'd0;
    if (eom) begin
      res.done = 1'b1;
      if (err2) begin
        res.cnt   = 2'd1;
        res.data  = 1'b0;
        res.err   = 1'b1;
        res.bytes = '0;
      end else if (!emit) begin
        res.cnt   = 2'd1;
        res.data  = 1'b0;
        res.bytes = '0;
      end
    end

    if (eom) begin
      store_nxt   = '0;
      fill_nxt    = '0;
      pad_nxt     = '0;
      emitted_nxt = '0;
      err_nxt     = 1'b0;
    end else begin
      store_nxt   = store1;
      fill_nxt    = fill1;
      pad_nxt     = pad1;
      emitted_nxt = emit ? total[CW-1:0] : emitted_r;
      err_nxt     = err2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= b64d_pkg::LIMIT_RESET;
      store_r   <= '0;
      fill_r    <= '0;
      pad_r     <= '0;
      emitted_r <= '0;
      err_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (step) begin
        store_r   <= store_nxt;
        fill_r    <= fill_nxt;
        pad_r     <= pad_nxt;
        emitted_r <= emitted_nxt;
        err_r     <= err_nxt;
      end
    end
  end

endmodule

// ===== src/b64d_outbuf.sv =====
`include "base64_stream_decoder_defines.svh"

module b64d_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  b64d_pkg::res_t     res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         data_byte,
  output logic               data_valid,
  output logic               last_of_run,
  output logic               message_done,
  output logic               decode_error
);

  logic [1:0]      cnt_r;
  logic [2:0][7:0] bytes_r;
  logic            data_r, done_r, err_r;
  logic            pop;

  assign out_valid    = (cnt_r != 2'd0);
  assign pop          = out_valid && out_ready;
  assign free         = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign data_byte    = bytes_r[0];
  assign data_valid   = data_r;
  assign last_of_run  = (cnt_r == 2'd1);
  assign message_done = done_r && (cnt_r == 2'd1);
  assign decode_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Load new results on each load; otherwise advance the byte queue on each output handshake.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= res.bytes;
      data_r  <= res.data;
      done_r  <= res.done;
      err_r   <= res.err;
    end else if (pop) begin
      bytes_r <= {8'h00, bytes_r[2], bytes_r[1]};
    end
  end

  `B64D_ASSERT_IMP(a_load_when_free, load, (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready), "load while results pending")
  `B64D_ASSERT_IMP(a_err_single, out_valid && err_r, (cnt_r == 2'd1) && !data_r && done_r, "error result not alone")
  `B64D_ASSERT_IMP(a_data_no_err, out_valid && data_r, !err_r, "data result flagged as error")
  `B64D_ASSERT_NXT(a_drain_empty, pop && (cnt_r == 2'd1) && !load, !out_valid, "buffer not empty after last result")

endmodule
